// ===== rtl/core/qte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// shared widths, constants and the arctangent table for the
// quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int ANGLE_BITS     = 16;

    localparam int Q_W        = 16;     // input field width
    localparam int A_W        = 16;     // output field width
    localparam int SUM_W      = 34;     // product sums, signed
    localparam int CX_W       = 35;     // cordic x/y datapath, signed
    localparam int Z_W        = 32;     // angle accumulator, full turn = 2^32
    localparam int RAD_W      = 64;     // root argument width
    localparam int ROOT_W     = 32;     // root result width
    localparam int CORDIC_N   = 32;
    localparam int ISQRT_N    = 32;

    localparam logic signed [SUM_W-1:0] ONE_Q =
        SUM_W'(64'd1 << (2 * QUAT_FRAC_BITS));

    localparam logic [Z_W-1:0] ACC_HALF    = 32'h8000_0000;
    localparam logic [Z_W-1:0] ACC_QUARTER = 32'h4000_0000;

    localparam logic [Z_W-1:0] ATAN_TURNS [CORDIC_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ===== rtl/core/qte_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [qte_pkg::RAD_W-1:0]    arg,
    output logic [qte_pkg::ROOT_W-1:0]   root
);
    import qte_pkg::*;

    logic [RAD_W-1:0] v_reg   [ISQRT_N];
    logic [RAD_W-1:0] res_reg [ISQRT_N];

    genvar i;
    generate
        for (i = 0; i < ISQRT_N; i++) begin : g_stage
            localparam logic [RAD_W-1:0] BIT = RAD_W'(64'd1 << (62 - 2 * i));
            logic [RAD_W-1:0] v_in, res_in, trial, v_next, res_next;

            if (i == 0) begin : g_first
                assign v_in   = arg;
                assign res_in = '0;
            end else begin : g_rest
                assign v_in   = v_reg[i-1];
                assign res_in = res_reg[i-1];
            end

            always_comb
            begin
                trial = res_in + BIT;
                if (v_in >= trial)
                begin
                    v_next   = v_in - trial;
                    res_next = (res_in >> 1) + BIT;
                end
                else
                begin
                    v_next   = v_in;
                    res_next = res_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[i]   <= v_next;
                    res_reg[i] <= res_next;
                end
            end
        end
    endgenerate

    assign root = res_reg[ISQRT_N-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/qte_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// four-quadrant arctangent: operand normalize stage then 32 vectoring stages
// ----------------------------------------------------------------------------
module qte_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [qte_pkg::SUM_W-1:0]  ys,
    input  logic signed [qte_pkg::SUM_W-1:0]  xs,
    output logic [qte_pkg::Z_W-1:0]           angle
);
    import qte_pkg::*;

    logic signed [CX_W-1:0] x_reg    [CORDIC_N+1];
    logic signed [CX_W-1:0] y_reg    [CORDIC_N+1];
    logic [Z_W-1:0]         z_reg    [CORDIC_N+1];
    logic                   zero_reg [CORDIC_N+1];

    // normalize magnitudes so the larger lies in [2^30, 2^31)
    logic [SUM_W-1:0]       ux, uy, m;
    logic [30:0]            nx, ny;
    logic signed [CX_W-1:0] x_next, y_next;
    logic [Z_W-1:0]         z_next;
    logic                   zero_next;

    always_comb
    begin
        ux = xs[SUM_W-1] ? SUM_W'(0) - $unsigned(xs) : $unsigned(xs);
        uy = ys[SUM_W-1] ? SUM_W'(0) - $unsigned(ys) : $unsigned(ys);
        m  = ux | uy;
        zero_next = (m == '0);
        priority if (m[33])
        begin
            ux = ux >> 3;
            uy = uy >> 3;
        end
        else if (m[32])
        begin
            ux = ux >> 2;
            uy = uy >> 2;
        end
        else if (m[31])
        begin
            ux = ux >> 1;
            uy = uy >> 1;
        end
        else
        begin
            // already below 2^31
            ux = ux;
            uy = uy;
        end
        nx = ux[30:0];
        ny = uy[30:0];
        for (int k = 16; k >= 1; k = k / 2)
        begin
            if ((nx | ny) < (31'd1 << (31 - k)))
            begin
                nx = nx << k;
                ny = ny << k;
            end
        end
        // turn by a half turn when the scaled cosine term is negative
        if (xs[SUM_W-1] && (nx != '0))
        begin
            x_next = CX_W'({1'b0, nx});
            y_next = ys[SUM_W-1] ? CX_W'({1'b0, ny}) : -CX_W'({1'b0, ny});
            z_next = ACC_HALF;
        end
        else
        begin
            x_next = CX_W'({1'b0, nx});
            y_next = ys[SUM_W-1] ? -CX_W'({1'b0, ny}) : CX_W'({1'b0, ny});
            z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= zero_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_N; i++) begin : g_iter
            logic signed [CX_W-1:0] xi_next, yi_next;
            logic [Z_W-1:0]         zi_next;

            always_comb
            begin
                if (!y_reg[i][CX_W-1])
                begin
                    xi_next = x_reg[i] + (y_reg[i] >>> i);
                    yi_next = y_reg[i] - (x_reg[i] >>> i);
                    zi_next = z_reg[i] + ATAN_TURNS[i];
                end
                else
                begin
                    xi_next = x_reg[i] - (y_reg[i] >>> i);
                    yi_next = y_reg[i] + (x_reg[i] >>> i);
                    zi_next = z_reg[i] - ATAN_TURNS[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1]    <= xi_next;
                    y_reg[i+1]    <= yi_next;
                    z_reg[i+1]    <= zi_next;
                    zero_reg[i+1] <= zero_reg[i];
                end
            end
        end
    endgenerate

    // zero vector gives angle zero
    assign angle = zero_reg[CORDIC_N] ? '0 : z_reg[CORDIC_N];

endmodule

// ===== rtl/core/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// unit quaternion in Q1.14 to roll, pitch, yaw binary angles (z-y-x order)
// ----------------------------------------------------------------------------
// usage:
//   input words arrive on s_tvalid/s_tready/s_tdata, one quaternion each;
//   results leave on m_tvalid/m_tready/m_tdata, one word per input word,
//   in input order
//   69 register stages: products, sums, root argument normalize, 32 square
//   root stages, one operand normalize stage, 32 cordic stages and the
//   output register; throughput is one word per clock unless the receiver
//   stalls; every stage advances together and the arctangent and square
//   root units are fully unrolled pipelines
//   when the receiver stalls with a word waiting in the output register,
//   the whole pipeline holds and s_tready drops; nothing is lost or repeated
//   while m_tready is high or the output register is empty, s_tready is high
//   reset clears all valid bits; data registers are not reset
//   angles: full turn = 65536, roll/yaw in [-pi, pi), pitch in [-pi/2, pi/2]
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [4*qte_pkg::Q_W-1:0]     s_tdata,   // qw, qx, qy, qz
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [3*qte_pkg::A_W-1:0]     m_tdata    // roll, pitch, yaw
);
    import qte_pkg::*;

    localparam int PIPE_N   = 3 + ISQRT_N + CORDIC_N + 1;
    localparam int ANGLE_SH = Z_W - ANGLE_BITS;
    localparam logic [Z_W-1:0] ROUND_HALF =
        (ANGLE_SH > 0) ? Z_W'(64'd1 << ((ANGLE_SH > 0) ? ANGLE_SH - 1 : 0)) : '0;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
    } rpy_ops_t;

    // whole pipeline advances when the output register can take a word
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // valid bits travel alongside each stage
    logic [PIPE_N-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_N-2:0], s_tvalid};
    end

    // stage 1: products
    logic signed [Q_W-1:0]     qw, qx, qy, qz;
    logic signed [2*Q_W-1:0]   wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [2*Q_W-1:0]   xy_reg, zz_reg, wy_reg, xz_reg;

    assign qw = $signed(s_tdata[Q_W-1:0]);
    assign qx = $signed(s_tdata[2*Q_W-1:Q_W]);
    assign qy = $signed(s_tdata[3*Q_W-1:2*Q_W]);
    assign qz = $signed(s_tdata[4*Q_W-1:3*Q_W]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
        end
    end

    // stage 2: product sums, root arguments clamped at zero
    rpy_ops_t                s2_ops_reg, s2_ops_next;
    logic [SUM_W-1:0]        us_reg, uc_reg;
    logic signed [SUM_W-1:0] d_sum, sa, ca;

    always_comb
    begin
        s2_ops_next.roll_y = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        s2_ops_next.roll_x = ONE_Q - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        s2_ops_next.yaw_y  = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        s2_ops_next.yaw_x  = ONE_Q - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        d_sum = (SUM_W'(wy_reg) - SUM_W'(xz_reg)) <<< 1;
        sa    = ONE_Q + d_sum;
        ca    = ONE_Q - d_sum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ops_reg <= s2_ops_next;
            us_reg     <= sa[SUM_W-1] ? '0 : $unsigned(sa);
            uc_reg     <= ca[SUM_W-1] ? '0 : $unsigned(ca);
        end
    end

    // stage 3: shift both root arguments left by an even amount until the larger is >= 2^60
    rpy_ops_t         s3_ops_reg;
    logic [RAD_W-1:0] rs_reg, rc_reg;
    logic [RAD_W-1:0] rs_next, rc_next;

    always_comb
    begin
        rs_next = RAD_W'(us_reg);
        rc_next = RAD_W'(uc_reg);
        for (int k = 32; k >= 2; k = k / 2)
        begin
            if ((rs_next | rc_next) < (64'd1 << (62 - k)))
            begin
                rs_next = rs_next << k;
                rc_next = rc_next << k;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ops_reg <= s2_ops_reg;
            rs_reg     <= rs_next;
            rc_reg     <= rc_next;
        end
    end

    // square roots; roll and yaw operands wait alongside
    logic [ROOT_W-1:0] root_s, root_c;

    qte_isqrt u_isqrt_s (
        .clk  (clk),
        .en   (adv),
        .arg  (rs_reg),
        .root (root_s)
    );

    qte_isqrt u_isqrt_c (
        .clk  (clk),
        .en   (adv),
        .arg  (rc_reg),
        .root (root_c)
    );

    rpy_ops_t dly_reg [ISQRT_N];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_reg[0] <= s3_ops_reg;
            for (int k = 1; k < ISQRT_N; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    // three arctangent pipelines run in lockstep
    logic [Z_W-1:0] roll_z, yaw_z, half_p;

    qte_cordic u_cordic_roll (
        .clk   (clk),
        .en    (adv),
        .ys    (dly_reg[ISQRT_N-1].roll_y),
        .xs    (dly_reg[ISQRT_N-1].roll_x),
        .angle (roll_z)
    );

    qte_cordic u_cordic_yaw (
        .clk   (clk),
        .en    (adv),
        .ys    (dly_reg[ISQRT_N-1].yaw_y),
        .xs    (dly_reg[ISQRT_N-1].yaw_x),
        .angle (yaw_z)
    );

    qte_cordic u_cordic_pitch (
        .clk   (clk),
        .en    (adv),
        .ys    ($signed(SUM_W'(root_s))),
        .xs    ($signed(SUM_W'(root_c))),
        .angle (half_p)
    );

    // output: pitch from twice the half angle, then round to output steps
    function automatic logic [A_W-1:0] to_field(input logic [Z_W-1:0] a);
        logic [Z_W-1:0] t;
        logic [Z_W-1:0] ext;
        t   = (a + ROUND_HALF) >> ANGLE_SH;
        ext = $unsigned($signed(t << ANGLE_SH) >>> ANGLE_SH);
        return ext[A_W-1:0];
    endfunction

    logic [Z_W-1:0]       pitch_z;
    logic [3*A_W-1:0]     out_next;
    logic [3*A_W-1:0]     out_reg;
    logic                 out_vld_reg;

    always_comb
    begin
        pitch_z  = (half_p << 1) - ACC_QUARTER;
        out_next = {to_field(yaw_z), to_field(pitch_z), to_field(roll_z)};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[PIPE_N-1];
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule
